// File: sv/dol_pkg.sv
// dol_pkg: shared types and codes of the date-ordered list store.
// No dependencies; every other file except dol_mem imports it.
`default_nettype none

package dol_pkg;

  localparam int REQ_W = 3;
  localparam int POS_W = 5;
  localparam int PAY_W = 32;
  localparam int YEAR_W = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT_AT  = 3'd4,
    REQ_DELETE_AT  = 3'd5,
    REQ_GET_AT     = 3'd6,
    REQ_INSERT_DATE = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_OPEN,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_TAKE_RD,
    S_TAKE_CAP,
    S_DN_RD,
    S_DN_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [PAY_W-1:0]     payload_out;
    logic [POS_W-1:0]     position_out;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

// File: sv/dol_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on dol_pkg for field widths.
`default_nettype none

interface dol_in_if import dol_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [POS_W-1:0]   position;
  logic [PAY_W-1:0]   payload;
  logic [YEAR_W-1:0]  birth_year;
  logic [MONTH_W-1:0] birth_month;
  logic [DAY_W-1:0]   birth_day;

  modport source (output valid, req_type, position, payload, birth_year, birth_month,
                  birth_day, input ready);
  modport sink (input valid, req_type, position, payload, birth_year, birth_month,
                birth_day, output ready);
endinterface

interface dol_out_if import dol_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [PAY_W-1:0]     payload_out;
  logic [POS_W-1:0]     position_out;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, payload_out, position_out, entry_count,
                  input ready);
  modport sink (input valid, status, payload_out, position_out, entry_count,
                output ready);
endinterface

`default_nettype wire

// File: sv/dol_mem.sv
// dol_mem: entry storage, one write port and one registered read port.
// No package dependency.
`default_nettype none

module dol_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 53,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/dol_step.sv
// dol_step: shared index step and date-key compare used by every walk.
// Depends on dol_pkg for the key width.
`default_nettype none

module dol_step import dol_pkg::*; #(
  parameter int IW = 4
) (
  input  wire logic [IW-1:0]    ptr,
  input  wire logic [KEY_W-1:0] key_stored,
  input  wire logic [KEY_W-1:0] key_new,
  output logic      [IW-1:0]    ptr_inc,
  output logic      [IW-1:0]    ptr_dec,
  output logic                  key_lt
);

  assign ptr_inc = ptr + IW'(1);
  assign ptr_dec = ptr - IW'(1);
  assign key_lt  = key_stored < key_new;

endmodule

`default_nettype wire

// File: sv/dol_ctrl.sv
// dol_ctrl: request sequencer; checks, searches and shifts entries one at a time.
// Depends on dol_pkg, dol_if, dol_mem and dol_step.
`default_nettype none

module dol_ctrl import dol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dol_in_if.sink    in_bus,
  input  wire logic res_free,
  output logic      res_load,
  output res_t      res
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int MW   = KEY_W + PAYLOAD_BITS;

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    ptr_r, ptr_nxt;
  logic [IW-1:0]    tgt_r, tgt_nxt;
  status_t          st_r, st_nxt;
  logic [PAY_W-1:0] pout_r, pout_nxt;
  logic [POS_W-1:0] posout_r, posout_nxt;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata, mem_rdata;
  logic [IW-1:0]    ptr_inc, ptr_dec;
  logic             key_lt;

  logic             full, empty;
  logic [CMPW-1:0]  pos_ext, cnt_ext;
  logic [CW-1:0]    cnt_dec;

  dol_mem #(.DEPTH(CAPACITY), .WIDTH(MW), .AW(IW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dol_step #(.IW(IW)) u_step (
    .ptr       (ptr_r),
    .key_stored(mem_rdata[MW-1:PAYLOAD_BITS]),
    .key_new   (key_r),
    .ptr_inc   (ptr_inc),
    .ptr_dec   (ptr_dec),
    .key_lt    (key_lt)
  );

  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);
  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(cnt_r);
  assign cnt_dec = cnt_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    req_r    <= req_nxt;
    pos_r    <= pos_nxt;
    pay_r    <= pay_nxt;
    key_r    <= key_nxt;
    ptr_r    <= ptr_nxt;
    tgt_r    <= tgt_nxt;
    st_r     <= st_nxt;
    pout_r   <= pout_nxt;
    posout_r <= posout_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    pos_nxt    = pos_r;
    pay_nxt    = pay_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    tgt_nxt    = tgt_r;
    st_nxt     = st_r;
    pout_nxt   = pout_r;
    posout_nxt = posout_r;
    mem_we     = 1'b0;
    mem_waddr  = ptr_inc;
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr_r;
    in_bus.ready = 1'b0;
    res_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          req_nxt    = req_t'(in_bus.req_type);
          pos_nxt    = in_bus.position;
          pay_nxt    = in_bus.payload;
          key_nxt    = {in_bus.birth_year, in_bus.birth_month, in_bus.birth_day};
          st_nxt     = ST_OK;
          pout_nxt   = '0;
          posout_nxt = '0;
          state_nxt  = S_CHECK;
        end
      end

      S_CHECK: begin
        ptr_nxt = '0;
        case (req_r) inside
          REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_AT, REQ_INSERT_DATE: begin
            if (full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else if (req_r == REQ_INSERT_AT && pos_ext > cnt_ext) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end else if (req_r == REQ_INSERT_DATE) begin
              tgt_nxt   = '0;
              state_nxt = empty ? S_OPEN : S_SRCH_RD;
            end else begin
              if (req_r == REQ_PUSH_BACK) tgt_nxt = IW'(cnt_r);
              else if (req_r == REQ_PUSH_FRONT) tgt_nxt = '0;
              else tgt_nxt = IW'(pos_r);
              state_nxt = S_OPEN;
            end
          end
          default: begin
            if (empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_DONE;
            end else if ((req_r == REQ_DELETE_AT || req_r == REQ_GET_AT) &&
                         pos_ext >= cnt_ext) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_DONE;
            end else begin
              if (req_r == REQ_POP_BACK) tgt_nxt = IW'(cnt_dec);
              else if (req_r == REQ_POP_FRONT) tgt_nxt = '0;
              else tgt_nxt = IW'(pos_r);
              if (req_r == REQ_POP_BACK) ptr_nxt = IW'(cnt_dec);
              else if (req_r == REQ_POP_FRONT) ptr_nxt = '0;
              else ptr_nxt = IW'(pos_r);
              state_nxt = S_TAKE_RD;
            end
          end
        endcase
      end

      // open a gap at tgt by moving entries up, last one first
      S_OPEN: begin
        if (cnt_r > CW'(tgt_r)) begin
          ptr_nxt   = IW'(cnt_dec);
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_UP_RD: begin
        mem_raddr = ptr_r;
        state_nxt = S_UP_WR;
      end

      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        mem_wdata = mem_rdata;
        if (ptr_r == tgt_r) begin
          state_nxt = S_PUT;
        end else begin
          ptr_nxt   = ptr_dec;
          state_nxt = S_UP_RD;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = {key_r, PAYLOAD_BITS'(pay_r)};
        cnt_nxt   = cnt_r + CW'(1);
        if (req_r == REQ_INSERT_DATE) posout_nxt = POS_W'(tgt_r);
        state_nxt = S_DONE;
      end

      S_TAKE_RD: begin
        mem_raddr = tgt_r;
        state_nxt = S_TAKE_CAP;
      end

      S_TAKE_CAP: begin
        if (req_r != REQ_DELETE_AT) pout_nxt = PAY_W'(mem_rdata[PAYLOAD_BITS-1:0]);
        if (req_r == REQ_GET_AT) begin
          state_nxt = S_DONE;
        end else if (CW'(tgt_r) + CW'(1) < cnt_r) begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_DN_RD;
        end else begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_DONE;
        end
      end

      // close the gap: entry at ptr moves down one place
      S_DN_RD: begin
        mem_raddr = ptr_r;
        state_nxt = S_DN_WR;
      end

      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_dec;
        mem_wdata = mem_rdata;
        if (CW'(ptr_r) == cnt_dec) begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_DN_RD;
        end
      end

      S_SRCH_RD: begin
        mem_raddr = ptr_r;
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (key_lt) begin
          if (CW'(ptr_inc) == cnt_r) begin
            tgt_nxt   = ptr_inc;
            state_nxt = S_OPEN;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = S_SRCH_RD;
          end
        end else begin
          tgt_nxt   = ptr_r;
          state_nxt = S_OPEN;
        end
      end

      S_DONE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status       = st_r;
    res.payload_out  = pout_r;
    res.position_out = posout_r;
    res.entry_count  = CNT_OUT_W'(cnt_r);
  end

endmodule

`default_nettype wire

// File: sv/date_ordered_list_store.sv
// date_ordered_list_store: top level; sequencer plus output result register.
// Depends on dol_pkg, dol_if and dol_ctrl.
//
//   channel   dir  handshake     beat contents
//   in_bus    in   valid/ready   req_type, position, payload, birth_{year,month,day}
//   out_bus   out  valid/ready   status, payload_out, position_out, entry_count
//
// One request at a time; ready is low from acceptance until the sequencer is idle again.
// Entries moved per request: insert count - index, delete/pop count - index - 1;
// a date insert also scans entries first. Each moved entry is read, then written,
// through the memory's read and write ports; get moves no entry.
// Reset (synchronous, rst_n low) empties the list; entry storage is not cleared.
// A result waiting in the output register does not stop the next request; the
// sequencer only holds its done state while that register is full and not being read.
`default_nettype none

module date_ordered_list_store import dol_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dol_in_if.sink    in_bus,
  dol_out_if.source out_bus
);

  logic res_free, res_load;
  res_t res, res_r;
  logic out_valid_r;

  assign res_free = !out_valid_r || out_bus.ready;

  dol_ctrl #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .res_free(res_free),
    .res_load(res_load),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = res_r.status;
  assign out_bus.payload_out  = res_r.payload_out;
  assign out_bus.position_out = res_r.position_out;
  assign out_bus.entry_count  = res_r.entry_count;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("request accepted while sequencer busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_bus.ready))
    else $error("pending result overwritten");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bus.status != ST_OK) |->
      (out_bus.payload_out == '0 && out_bus.position_out == '0))
    else $error("error result carries data");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

`default_nettype wire
